### hw/rtl/iir_df1_pkg.sv
`default_nettype none

package iir_df1_pkg;

    // filter shape
    localparam int FILTER_ORDER   = 3;
    localparam int COEF_FRAC_BITS = 14;
    localparam int HIST_DEPTH     = 3;
    localparam int NUM_TAPS       = 2 * FILTER_ORDER + 1;

    // widths
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 18;
    localparam int PROD_W   = COEF_W + SAMPLE_W;
    localparam int ACC_W    = PROD_W + $clog2(NUM_TAPS + 1);
    localparam int REM_W    = COEF_W + 1;
    localparam int CNT_W    = $clog2(ACC_W);

    // register map
    localparam int NUM_REGS  = 8;
    localparam int IDX_W     = $clog2(NUM_REGS);
    localparam int REG_FEED0 = 0;
    localparam int REG_NORM  = 4;

    localparam logic signed [COEF_W-1:0]   COEF_ONE = COEF_W'(1 << COEF_FRAC_BITS);
    localparam logic signed [SAMPLE_W-1:0] OUT_MAX  = SAMPLE_W'(32767);
    localparam logic signed [SAMPLE_W-1:0] OUT_MIN  = SAMPLE_W'(-32768);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

### hw/rtl/iir_filter_direct_form_one.sv
`default_nettype none
// Direct form I recursive filter, order FILTER_ORDER, 16-bit samples, Q4.14 coefficients.
// Input channel (i_s_axis_*): one sample per request; o_s_axis_tready is high only
// while the sequencer is idle. Output channel (o_m_axis_*): one filtered sample per
// input, with tuser flagging saturation (clipped output or zero norm coefficient).
// Coefficients are written through i_cfg_we / i_cfg_index / i_cfg_data; the user must
// write them only while idle, the block itself does not enforce it.
// One shared 18x16 multiplier runs the 2*FILTER_ORDER+1 products, each held in a
// product register before it is accumulated, then a restoring divider produces one
// quotient bit per cycle for ACC_W (37) quotient bits, then the done state loads the
// output register. Ready rises as the result enters the output register, and no new
// sample is taken before that; a zero norm coefficient skips the divider.
// The output register holds a finished result while the receiver stalls; the next
// sample is taken meanwhile and its result waits in the done state until the
// output register frees up.
// Reset (synchronous, active low) restores b0 = a0 = 1.0, all other coefficients
// zero, clears both delay lines and drops any pending result.
module iir_filter_direct_form_one
    import iir_df1_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // sample request
    input  wire                 i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  wire  [15:0]         i_s_axis_tdata,   // [15:0] sample_in
    // result request
    output logic                o_m_axis_tvalid,
    input  wire                 i_m_axis_tready,
    output logic [15:0]         o_m_axis_tdata,   // [15:0] filtered_out
    output logic                o_m_axis_tuser,   // [0] saturated
    // coefficient writes
    input  wire                 i_cfg_we,
    input  wire  [IDX_W-1:0]    i_cfg_index,
    input  wire  [COEF_W-1:0]   i_cfg_data
);

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic signed [COEF_W-1:0]   r_coef [NUM_REGS];
    logic signed [SAMPLE_W-1:0] r_xh [HIST_DEPTH];
    logic signed [SAMPLE_W-1:0] r_yh [HIST_DEPTH];
    logic signed [SAMPLE_W-1:0] r_x0;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_sub;
    logic signed [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]         r_num;
    logic [REM_W-1:0]         r_rem;
    logic [COEF_W-1:0]        r_den_mag;
    logic                     r_neg;
    logic                     r_zden;

    logic [SAMPLE_W-1:0] r_out_data;
    logic                r_out_sat;
    logic                r_out_valid;

    logic signed [COEF_W-1:0]   tap_coef;
    logic signed [SAMPLE_W-1:0] tap_smp;
    logic                       tap_sub;
    logic signed [ACC_W-1:0]    acc_next;
    logic [ACC_W-1:0]           acc_mag;
    logic [REM_W-1:0]           rem_sh;
    logic                       rem_ge;
    logic [SAMPLE_W-1:0]        res_data;
    logic                       res_sat;
    logic                       s_accept;
    logic                       out_load;
    logic                       mac_last;
    logic                       div_last;

    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign mac_last = (r_cnt == CNT_W'(NUM_TAPS));
    assign div_last = (r_cnt == CNT_W'(ACC_W - 1));
    assign out_load = (r_state == ST_DONE) && (!r_out_valid || i_m_axis_tready);

    // tap operand select for the shared multiplier
    always_comb begin
        tap_coef = '0;
        tap_smp  = '0;
        tap_sub  = 1'b0;
        for (int j = 0; j < NUM_TAPS; j++) begin
            if (r_cnt == CNT_W'(j)) begin
                if (j == 0) begin
                    tap_coef = r_coef[REG_FEED0];
                    tap_smp  = r_x0;
                end else if (j <= FILTER_ORDER) begin
                    tap_coef = r_coef[REG_FEED0 + j];
                    tap_smp  = r_xh[(j > 0) ? j - 1 : 0];
                end else begin
                    tap_coef = r_coef[REG_NORM + j - FILTER_ORDER];
                    tap_smp  = r_yh[(j > FILTER_ORDER) ? j - FILTER_ORDER - 1 : 0];
                    tap_sub  = 1'b1;
                end
            end
        end
    end

    // accumulate the registered product
    always_comb begin
        if (r_prod_sub) begin
            acc_next = r_acc - ACC_W'(r_prod);
        end else begin
            acc_next = r_acc + ACC_W'(r_prod);
        end
        acc_mag = acc_next[ACC_W-1] ? ACC_W'(-acc_next) : ACC_W'(acc_next);
    end

    // restoring divider step
    always_comb begin
        rem_sh = {r_rem[REM_W-2:0], r_num[ACC_W-1]};
        rem_ge = (rem_sh >= {1'b0, r_den_mag});
    end

    // saturate the quotient to 16 bits
    always_comb begin
        res_sat  = 1'b0;
        res_data = r_num[SAMPLE_W-1:0];
        if (r_zden) begin
            res_sat  = 1'b1;
            res_data = r_neg ? OUT_MIN : OUT_MAX;
        end else if (!r_neg) begin
            if (r_num > ACC_W'(32767)) begin
                res_sat  = 1'b1;
                res_data = OUT_MAX;
            end
        end else begin
            if (r_num > ACC_W'(32768)) begin
                res_sat  = 1'b1;
                res_data = OUT_MIN;
            end else begin
                res_data = SAMPLE_W'(-r_num[SAMPLE_W-1:0]);
            end
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = ST_MAC;
                    n_cnt   = '0;
                end
            end
            ST_MAC: begin
                n_cnt = r_cnt + 1'b1;
                if (mac_last) begin
                    n_cnt   = '0;
                    n_state = (r_coef[REG_NORM] == '0) ? ST_DONE : ST_DIV;
                end
            end
            ST_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (div_last) begin
                    n_cnt   = '0;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);

    // coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                r_coef[k] <= '0;
            end
            r_coef[REG_FEED0] <= COEF_ONE;
            r_coef[REG_NORM]  <= COEF_ONE;
        end else if (i_cfg_we) begin
            r_coef[i_cfg_index] <= i_cfg_data;
        end
    end

    // delay lines, shifted when a result is handed to the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
                r_xh[k] <= '0;
                r_yh[k] <= '0;
            end
        end else if (out_load) begin
            for (int k = HIST_DEPTH - 1; k > 0; k--) begin
                r_xh[k] <= r_xh[k-1];
                r_yh[k] <= r_yh[k-1];
            end
            r_xh[0] <= r_x0;
            r_yh[0] <= res_data;
        end
    end

    // datapath: multiply-accumulate then serial divide
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_x0       <= i_s_axis_tdata;
            r_acc      <= '0;
            r_prod     <= '0;
            r_prod_sub <= 1'b0;
        end
        if (r_state == ST_MAC) begin
            r_prod     <= tap_coef * tap_smp;
            r_prod_sub <= tap_sub;
            r_acc      <= acc_next;
            if (mac_last) begin
                r_num     <= acc_mag;
                r_rem     <= '0;
                r_zden    <= (r_coef[REG_NORM] == '0);
                r_neg     <= (r_coef[REG_NORM] == '0) ? acc_next[ACC_W-1]
                           : (acc_next[ACC_W-1] ^ r_coef[REG_NORM][COEF_W-1]);
                r_den_mag <= r_coef[REG_NORM][COEF_W-1] ? COEF_W'(-r_coef[REG_NORM])
                           : COEF_W'(r_coef[REG_NORM]);
            end
        end
        if (r_state == ST_DIV) begin
            r_rem <= rem_ge ? REM_W'(rem_sh - {1'b0, r_den_mag}) : rem_sh;
            r_num <= {r_num[ACC_W-2:0], rem_ge};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= res_data;
            r_out_sat  <= res_sat;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_sat;

    // checks
    a_accept_starts_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state == ST_MAC) && (r_cnt == '0))
        else $error("accepted sample did not start the product sequence");

    a_div_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) && !r_zden |-> (r_rem < {1'b0, r_den_mag}))
        else $error("divider remainder not below divisor");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> ($past(r_state) == ST_DONE))
        else $error("result shown without a finished computation");

    a_zero_den_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && r_zden |=> o_m_axis_tuser)
        else $error("zero norm coefficient result not flagged");

endmodule

`default_nettype wire
